>>> src/ccfe_pkg.sv
// shared constants, command codes and entry/result types of the connection cache
package ccfe_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_W     = 48;
  localparam int HANDLE_W  = 16;
  localparam int STAMP_W   = 32;
  localparam int CMD_W     = 2;
  localparam int ACT_W     = 5;

  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ACT_RESET = (DEPTH < 16) ? DEPTH : 16;
  localparam int ACT_MAX   = (DEPTH < 31) ? DEPTH : 31;

  localparam int IN_FIELD_W  = KEY_W + HANDLE_W;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 3 + 2 * HANDLE_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  // low bits match the tdata layout of the result channel
  typedef struct packed {
    logic                last;
    logic                full;
    logic [HANDLE_W-1:0] rel_handle;
    logic                rel_valid;
    logic [HANDLE_W-1:0] found_handle;
    logic                hit;
  } res_t;

endpackage

>>> src/connection_cache_fifo_evict.sv
// connection cache: fully associative key to handle table with oldest-first eviction
// find and remove scan the active slots, then pick, fetch and output the lowest
//   match (find) or every match in turn (remove); add writes a free slot directly,
//   or first scans for the oldest stamp; clear releases every valid active slot
// throughput: one request at a time, bounded by the table memory scan
// reset (synchronous): all slots invalid, insertion counter zero, active_entries 16;
//   key/handle/stamp memory is not cleared, find and remove ignore invalid slots
module connection_cache_fifo_evict (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: key, handle
  input  logic [ccfe_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: command
  input  logic [ccfe_pkg::CMD_W-1:0]       in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata: hit, found_handle, released_valid, released_handle, full_res, zero pad
  output logic [ccfe_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ccfe_pkg::ACT_W-1:0]       cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);
  import ccfe_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_PICK  = 6'b000100,
    S_FETCH = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  function automatic logic [IDX_W-1:0] low_idx(input logic [DEPTH-1:0] m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (m[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [HANDLE_W-1:0]  handle_r, handle_nxt;
  logic [ACT_W-1:0]     active_r, active_nxt;
  logic [STAMP_W-1:0]   ins_cnt_r, ins_cnt_nxt;
  logic [DEPTH-1:0]     valid_r, valid_nxt;
  logic [DEPTH-1:0]     mask_r, mask_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [STAMP_W-1:0]   min_stamp_r, min_stamp_nxt;
  logic [IDX_W-1:0]     min_idx_r, min_idx_nxt;
  logic [HANDLE_W-1:0]  min_handle_r, min_handle_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic                 rel_v_r, rel_v_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  res_t                 res_r, res_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic                 out_valid_r, out_valid_nxt;

  entry_t               mem [DEPTH];
  entry_t               rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  entry_t               wr_data;

  logic [CNT_W-1:0]     n_cnt;
  logic [DEPTH-1:0]     act_mask;
  logic [DEPTH-1:0]     free_mask;
  logic                 full_now;
  logic                 issue;
  logic [DEPTH-1:0]     pick_bit;
  logic [DEPTH-1:0]     vset;
  logic                 out_free;

  assign n_cnt = CNT_W'(active_r);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      act_mask[i] = CNT_W'(i) < n_cnt;
    end
  end

  assign free_mask = ~valid_r & act_mask;
  assign full_now  = (valid_r & act_mask) == act_mask;
  assign issue     = rd_cnt_r < n_cnt;
  assign pick_bit  = DEPTH'(1) << pick_r;
  assign vset      = valid_r | (DEPTH'(1) << slot_r);
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready  = state_r == S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = OUT_DATA_W'(out_res_r[OUT_FIELD_W-1:0]);

  // table memory, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign wr_data.key    = key_r;
  assign wr_data.handle = handle_r;
  assign wr_data.stamp  = ins_cnt_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    handle_nxt     = handle_r;
    active_nxt     = active_r;
    ins_cnt_nxt    = ins_cnt_r;
    valid_nxt      = valid_r;
    mask_nxt       = mask_r;
    rd_cnt_nxt     = rd_cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    min_stamp_nxt  = min_stamp_r;
    min_idx_nxt    = min_idx_r;
    min_handle_nxt = min_handle_r;
    slot_nxt       = slot_r;
    rel_v_nxt      = rel_v_r;
    pick_nxt       = pick_r;
    res_nxt        = res_r;
    out_res_nxt    = out_res_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    rd_addr        = rd_cnt_r[IDX_W-1:0];
    mem_we         = 1'b0;

    // shrinking writes are dropped, oversized ones saturate
    if (cfg_valid && cfg_data >= active_r) begin
      active_nxt = (cfg_data > ACT_W'(ACT_MAX)) ? ACT_W'(ACT_MAX) : cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = cmd_t'(in_tuser);
          key_nxt    = in_tdata[KEY_W-1:0];
          handle_nxt = in_tdata[IN_FIELD_W-1:KEY_W];
          rd_cnt_nxt = '0;
          mask_nxt   = '0;
          unique case (cmd_t'(in_tuser))
            CMD_ADD: begin
              if (ins_cnt_r != '1) ins_cnt_nxt = ins_cnt_r + 1'b1;
              if (free_mask != '0) begin
                slot_nxt  = low_idx(free_mask);
                rel_v_nxt = 1'b0;
                state_nxt = S_WRITE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_CLEAR: begin
              mask_nxt  = valid_r & act_mask;
              state_nxt = S_PICK;
            end
            default: state_nxt = S_SCAN;
          endcase
        end
      end

      S_SCAN: begin
        chk_vld_nxt = issue;
        chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
        rd_cnt_nxt  = rd_cnt_r + CNT_W'(issue);
        if (chk_vld_r) begin
          if (cmd_r == CMD_ADD) begin
            // strict compare keeps the lowest index among equal stamps
            if (chk_idx_r == '0 || rd_data_r.stamp < min_stamp_r) begin
              min_stamp_nxt  = rd_data_r.stamp;
              min_idx_nxt    = chk_idx_r;
              min_handle_nxt = rd_data_r.handle;
            end
          end else begin
            mask_nxt[chk_idx_r] = valid_r[chk_idx_r] && (rd_data_r.key == key_r);
          end
        end
        if (!issue && !chk_vld_r) begin
          if (cmd_r == CMD_ADD) begin
            slot_nxt  = min_idx_r;
            rel_v_nxt = 1'b1;
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_PICK;
          end
        end
      end

      S_PICK: begin
        if (mask_r == '0) begin
          res_nxt      = '0;
          res_nxt.full = full_now;
          res_nxt.last = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          pick_nxt  = low_idx(mask_r);
          rd_addr   = low_idx(mask_r);
          state_nxt = S_FETCH;
        end
      end

      S_FETCH: begin
        res_nxt = '0;
        if (cmd_r == CMD_FIND) begin
          res_nxt.hit          = 1'b1;
          res_nxt.found_handle = rd_data_r.handle;
          res_nxt.full         = full_now;
          res_nxt.last         = 1'b1;
        end else begin
          // a release always leaves an active slot free
          res_nxt.rel_valid  = 1'b1;
          res_nxt.rel_handle = rd_data_r.handle;
          res_nxt.last       = (mask_r & ~pick_bit) == '0;
          mask_nxt           = mask_r & ~pick_bit;
          valid_nxt          = valid_r & ~pick_bit;
        end
        state_nxt = S_OUT;
      end

      S_WRITE: begin
        mem_we             = 1'b1;
        valid_nxt          = vset;
        res_nxt            = '0;
        res_nxt.rel_valid  = rel_v_r;
        res_nxt.rel_handle = rel_v_r ? min_handle_r : '0;
        res_nxt.full       = (vset & act_mask) == act_mask;
        res_nxt.last       = 1'b1;
        state_nxt          = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = res_r.last ? S_IDLE : S_PICK;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACT_W'(ACT_RESET);
      ins_cnt_r   <= '0;
      valid_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      ins_cnt_r   <= ins_cnt_nxt;
      valid_r     <= valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    handle_r     <= handle_nxt;
    mask_r       <= mask_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    min_stamp_r  <= min_stamp_nxt;
    min_idx_r    <= min_idx_nxt;
    min_handle_r <= min_handle_nxt;
    slot_r       <= slot_nxt;
    rel_v_r      <= rel_v_nxt;
    pick_r       <= pick_nxt;
    res_r        <= res_nxt;
    out_res_r    <= out_res_nxt;
  end

endmodule

>>> src/ccfe_checker.sv
// port-level checks for the connection cache, bound to the top level
module ccfe_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic [ccfe_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready
);
  import ccfe_pkg::*;

  localparam int HIT_B  = 0;
  localparam int RV_B   = HANDLE_W + 1;
  localparam int FULL_B = 2 * HANDLE_W + 2;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a result is never both a find hit and a release
  a_hit_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[HIT_B] && out_tdata[RV_B]))
    else $error("hit and release in one result");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[HIT_B] |-> out_tdata[HANDLE_W:1] == '0)
    else $error("found handle set without hit");

  // only multi-release requests give non-final results, and those leave a free slot
  a_mid_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[RV_B] && !out_tdata[FULL_B])
    else $error("non-final result that is not a release");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind connection_cache_fifo_evict ccfe_checker u_ccfe_checker (.*);

>>> test/testbench.sv
// self-checking testbench for the connection cache with oldest-first eviction
`timescale 1ns / 100ps

module testbench;
  import ccfe_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASE_ITEMS  = 120;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [ACT_W-1:0]      cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  connection_cache_fifo_evict dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  // predicted table contents
  logic                tbl_valid  [DEPTH];
  logic [KEY_W-1:0]    tbl_key    [DEPTH];
  logic [HANDLE_W-1:0] tbl_handle [DEPTH];
  logic [STAMP_W-1:0]  tbl_stamp  [DEPTH];
  logic [STAMP_W-1:0]  add_stamp;
  int                  act_entries;

  res_t pending_results[$];

  typedef struct {
    cmd_t                cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    int                  reps;
    bit                  typed;
    res_t                want;
  } dir_row_t;

  dir_row_t         dir_rows[$];
  logic [KEY_W-1:0] key_pool[8];

  int  cycle_count;
  int  mismatches;
  int  unexpected;
  int  result_count;
  int  release_count;
  int  cmd_count[4];
  bit  calm;
  bit  want_hold;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void predict_config(input logic [ACT_W-1:0] val);
    int v;
    v = int'(val);
    if (v >= act_entries) act_entries = (v > DEPTH) ? DEPTH : v;
  endfunction

  // applies one request to the predicted table and optionally queues its results
  function automatic void predict_cache_request(input cmd_t cmd, input logic [KEY_W-1:0] key,
                                                input logic [HANDLE_W-1:0] handle,
                                                input bit record);
    int   n;
    int   slot;
    bit   full_now;
    res_t r;
    res_t outs[$];
    n = act_entries;
    if (n > DEPTH) n = DEPTH;
    if (n < 1) n = 1;
    r = '0;
    case (cmd)
      CMD_FIND: begin
        for (int i = 0; i < n; i++) begin
          if (tbl_valid[i] && tbl_key[i] == key) begin
            r.hit = 1'b1;
            r.found_handle = tbl_handle[i];
            break;
          end
        end
        outs.push_back(r);
      end
      CMD_ADD: begin
        if (add_stamp != '1) add_stamp = add_stamp + 1'b1;
        slot = -1;
        for (int i = 0; i < n; i++) begin
          if (!tbl_valid[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          // evict the oldest stamp, lowest index on ties
          slot = 0;
          for (int i = 1; i < n; i++)
            if (tbl_stamp[i] < tbl_stamp[slot]) slot = i;
          r.rel_valid = 1'b1;
          r.rel_handle = tbl_handle[slot];
        end
        tbl_valid[slot]  = 1'b1;
        tbl_key[slot]    = key;
        tbl_handle[slot] = handle;
        tbl_stamp[slot]  = add_stamp;
        outs.push_back(r);
      end
      default: begin
        for (int i = 0; i < n; i++) begin
          if (tbl_valid[i] && (cmd == CMD_CLEAR || tbl_key[i] == key)) begin
            r = '0;
            r.rel_valid = 1'b1;
            r.rel_handle = tbl_handle[i];
            outs.push_back(r);
            tbl_valid[i]  = 1'b0;
            tbl_key[i]    = '0;
            tbl_handle[i] = '0;
            tbl_stamp[i]  = '0;
          end
        end
        if (outs.size() == 0) outs.push_back('0);
      end
    endcase
    full_now = 1'b1;
    for (int i = 0; i < n; i++)
      if (!tbl_valid[i]) full_now = 1'b0;
    foreach (outs[i]) begin
      outs[i].full = full_now;
      outs[i].last = (i == outs.size() - 1);
      if (record) pending_results.push_back(outs[i]);
    end
  endfunction

  function automatic res_t one_result(input logic hit, input logic [HANDLE_W-1:0] fh,
                                      input logic rv, input logic [HANDLE_W-1:0] rh,
                                      input logic full);
    res_t r;
    r.hit = hit;
    r.found_handle = fh;
    r.rel_valid = rv;
    r.rel_handle = rh;
    r.full = full;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_row(input cmd_t cmd, input logic [KEY_W-1:0] key,
                         input logic [HANDLE_W-1:0] handle, input int reps,
                         input bit typed, input res_t want);
    dir_row_t row;
    row.cmd = cmd;
    row.key = key;
    row.handle = handle;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      @(negedge clk) in_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_request(input cmd_t cmd, input logic [KEY_W-1:0] key,
                              input logic [HANDLE_W-1:0] handle, input bit typed,
                              input res_t want);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = '0;
    in_tdata[KEY_W-1:0] = key;
    in_tdata[KEY_W +: HANDLE_W] = handle;
    do @(posedge clk); while (!in_tready);
    predict_cache_request(cmd, key, handle, !typed);
    if (typed) pending_results.push_back(want);
    cmd_count[int'(cmd)]++;
  endtask

  task automatic write_active(input logic [ACT_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    predict_config(val);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // sender stays quiet until every queued result is back, then lets the block settle
  task automatic drain();
    @(negedge clk) in_tvalid = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic refresh_pool();
    foreach (key_pool[i]) key_pool[i] = KEY_W'({$urandom, $urandom});
    key_pool[7] = '1;
  endtask

  task automatic random_phase(input int items);
    cmd_t                cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    int                  p;
    refresh_pool();
    for (int i = 0; i < items; i++) begin
      p = $urandom_range(0, 99);
      if (p < 45) cmd = CMD_ADD;
      else if (p < 80) cmd = CMD_FIND;
      else if (p < 96) cmd = CMD_REMOVE;
      else cmd = CMD_CLEAR;
      // mostly keys from a small pool so finds and removes hit and duplicates occur
      if ($urandom_range(0, 9) == 0) key = KEY_W'({$urandom, $urandom});
      else key = key_pool[$urandom_range(0, 7)];
      handle = HANDLE_W'($urandom);
      sender_gap();
      send_request(cmd, key, handle, 1'b0, '0);
    end
  endtask

  function automatic void note_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: want hit=%0d fh=%h rv=%0d rh=%h full=%0d last=%0d",
               $realtime, what, want.hit, want.found_handle, want.rel_valid, want.rel_handle,
               want.full, want.last);
      $display("%0t: %s:  got hit=%0d fh=%h rv=%0d rh=%h full=%0d last=%0d",
               $realtime, what, got.hit, got.found_handle, got.rel_valid, got.rel_handle,
               got.full, got.last);
    end
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'({out_tlast, out_tdata[OUT_FIELD_W-1:0]});
      result_count++;
      if (got.rel_valid) release_count++;
      if (pending_results.size() == 0) begin
        unexpected++;
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL connection_cache_fifo_evict");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin : recv_proc
    int burst;
    burst = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (want_hold && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (burst == 0 && !calm && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 17);
      if (burst > 0) begin
        out_tready = 1'b0;
        burst--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  initial begin
    int leftover;
    in_tdata  = '0;
    in_tuser  = CMD_FIND;
    in_tvalid = 1'b0;
    cfg_data  = '0;
    cfg_valid = 1'b0;
    rst_n     = 1'b0;
    calm      = 1'b0;
    want_hold = 1'b0;
    hold_done = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    unexpected = 0;
    result_count = 0;
    release_count = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    foreach (tbl_valid[i]) begin
      tbl_valid[i]  = 1'b0;
      tbl_key[i]    = '0;
      tbl_handle[i] = '0;
      tbl_stamp[i]  = '0;
    end
    add_stamp = '0;
    act_entries = ACT_RESET;

    // empty table, extremes of key and handle, duplicates, eviction, full clear
    add_row(CMD_FIND,   '0, '0, 1, 1, one_result(0, '0, 0, '0, 0));
    add_row(CMD_REMOVE, '0, '0, 1, 1, one_result(0, '0, 0, '0, 0));
    add_row(CMD_CLEAR,  '1, '1, 1, 1, one_result(0, '0, 0, '0, 0));
    add_row(CMD_ADD,    '0, '0, 1, 1, one_result(0, '0, 0, '0, 0));
    add_row(CMD_ADD,    '1, '1, 1, 1, one_result(0, '0, 0, '0, 0));
    add_row(CMD_FIND,   '1, '0, 1, 1, one_result(1, '1, 0, '0, 0));
    add_row(CMD_FIND,   '0, '1, 1, 1, one_result(1, '0, 0, '0, 0));
    add_row(CMD_ADD,    '1, 16'h1234, 1, 0, '0);
    add_row(CMD_FIND,   '1, '0, 1, 0, '0);
    add_row(CMD_REMOVE, '1, '0, 1, 0, '0);
    add_row(CMD_ADD,    48'h1000, 16'h0100, 15, 0, '0);
    add_row(CMD_ADD,    48'h8000_0000_0000, 16'h8000, 1, 0, '0);
    add_row(CMD_FIND,   48'h1005, '0, 1, 0, '0);
    add_row(CMD_REMOVE, 48'h1007, '0, 1, 0, '0);
    add_row(CMD_ADD,    48'h5555_5555_5555, 16'h5555, 1, 0, '0);
    add_row(CMD_ADD,    48'haaaa_aaaa_aaaa, 16'haaaa, 1, 0, '0);
    add_row(CMD_CLEAR,  '0, '0, 1, 0, '0);
    add_row(CMD_FIND,   48'h8000_0000_0000, '0, 1, 1, one_result(0, '0, 0, '0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    write_active(5'd0);
    foreach (dir_rows[i])
      for (int r = 0; r < dir_rows[i].reps; r++) begin
        sender_gap();
        send_request(dir_rows[i].cmd, dir_rows[i].key + KEY_W'(r),
                     dir_rows[i].handle + HANDLE_W'(r),
                     dir_rows[i].typed, dir_rows[i].want);
      end

    drain();
    write_active(5'd1);
    random_phase(PHASE_ITEMS);
    drain();
    write_active(5'd31);
    want_hold = 1'b1;
    random_phase(PHASE_ITEMS);
    drain();
    write_active(5'd16);
    random_phase(PHASE_ITEMS);
    drain();
    write_active(5'd17);
    calm = 1'b1;
    random_phase(PHASE_ITEMS);
    drain();

    leftover = pending_results.size();
    $display("covered %0d requests: %0d find, %0d add, %0d remove, %0d clear",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3], cmd_count[0],
             cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("%0d results, %0d releases; %0d mismatches (%0d unexpected), %0d missing",
             result_count, release_count, mismatches, unexpected, leftover);
    if (mismatches == 0 && leftover == 0)
      $display("PASS connection_cache_fifo_evict");
    else
      $display("FAIL connection_cache_fifo_evict");
    $finish;
  end

endmodule
